// File: hw/rtl/ghtc_pkg.sv
// ----------------------------------------------------------------------------
// Gyro heading turn controller package
// Shared constants, command codes, register indexes and payload types.
// ----------------------------------------------------------------------------
`default_nettype none

package ghtc_pkg;

  localparam int SAMPLE_BITS       = 10;
  localparam int CAL_SAMPLES_DEF   = 10;
  localparam int HEADING_SCALE_DEF = 10;
  localparam int CFG_DATA_W        = 8;

  localparam logic [CFG_DATA_W-1:0] DEADBAND_RST = 8'd3;

  typedef enum logic [1:0] {
    FUNC_TICK     = 2'd0,
    FUNC_TURN_ABS = 2'd1,
    FUNC_TURN_REL = 2'd2,
    FUNC_RECAL    = 2'd3
  } func_t;

  typedef enum logic {
    REG_MOUNT_REV = 1'b0,
    REG_DEADBAND  = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    func_t                  func;
    logic [SAMPLE_BITS-1:0] gyro_sample;
    logic signed [15:0]     turn_angle;
    logic signed [7:0]      turn_speed;
  } in_t;

  typedef struct packed {
    logic signed [7:0]  left_power;
    logic signed [7:0]  right_power;
    logic signed [15:0] heading;
    logic               turn_active;
    logic               calibrating;
    logic               turn_done;
  } out_t;

endpackage

`default_nettype wire

// File: hw/rtl/gyro_heading_turn_controller_unit.sv
// ----------------------------------------------------------------------------
// Gyro heading turn controller
// Integrates gyro rate samples into a heading and runs a bang-bang turn.
// ----------------------------------------------------------------------------
// Each input transaction is one sample period: a rate sample tick, an
// absolute or relative turn start, or a recalibrate command. Every input
// transaction produces exactly one output transaction with the wheel powers,
// the heading and the turn and calibration flags after that item.
// The configuration port writes the mount direction and the turn deadband;
// the user must use it only while the block is idle, which is not enforced.
// Throughput is one transaction per cycle while the output is not stalled.
// The item passes four register stages: state update at acceptance,
// magnitude and saturation check, reciprocal multiply for the heading
// scale, and turn control into the output register.
// A stalled output holds its transaction; in_stall then rises in the same
// cycle and the whole pipeline holds until the output is taken.
// Reset clears the pipeline, starts a new offset calibration, zeroes the
// accumulator and cancels any turn. The deadband resets to three.
// ----------------------------------------------------------------------------
`default_nettype none

module gyro_heading_turn_controller_unit import ghtc_pkg::*; #(
  parameter int CAL_SAMPLES   = CAL_SAMPLES_DEF,
  parameter int HEADING_SCALE = HEADING_SCALE_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_t                   in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_t                  out_data,
  input  logic                  cfg_we,
  input  cfg_idx_t              cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int CNT_W  = $clog2(CAL_SAMPLES + 1);
  localparam int SUM_W  = SAMPLE_BITS + $clog2(CAL_SAMPLES + 1);
  localparam int CK     = SUM_W + $clog2(CAL_SAMPLES) + 1;
  localparam int CM_W   = SUM_W + 2;
  localparam int CPRD_W = CK + SAMPLE_BITS;
  localparam logic [63:0] CM_FULL =
    ((64'd1 << CK) + 64'(CAL_SAMPLES) - 64'd1) / 64'(CAL_SAMPLES);
  localparam logic [CM_W-1:0] CM = CM_FULL[CM_W-1:0];

  localparam logic [31:0] LIM_P = 32'(32768 * HEADING_SCALE);
  localparam logic [31:0] LIM_N = 32'(32769 * HEADING_SCALE);
  localparam int MAG_W  = $clog2(32769 * HEADING_SCALE);
  localparam int HK     = MAG_W + $clog2(HEADING_SCALE) + 1;
  localparam int HM_W   = MAG_W + 2;
  localparam int HPRD_W = HK + 17;
  localparam logic [63:0] HM_FULL =
    ((64'd1 << HK) + 64'(HEADING_SCALE) - 64'd1) / 64'(HEADING_SCALE);
  localparam logic [HM_W-1:0] HM = HM_FULL[HM_W-1:0];

  logic                   mount_rev_r;
  logic [CFG_DATA_W-1:0]  deadband_r;

  logic                   en;
  logic                   in_acc;

  logic                   cal_active_r, cal_active_nxt;
  logic [CNT_W-1:0]       cal_cnt_r, cal_cnt_nxt;
  logic [SUM_W-1:0]       cal_sum_r, cal_sum_nxt;
  logic [SAMPLE_BITS-1:0] zero_offset_r, zero_offset_nxt;
  logic [31:0]            acc_r, acc_nxt;

  logic [CNT_W-1:0]       cal_cnt_inc;
  logic [SUM_W-1:0]       cal_sum_inc;
  logic                   cal_fin;
  logic [CPRD_W-1:0]      cal_prod;
  logic signed [SAMPLE_BITS:0] diff, rate;
  logic [31:0]            delta;

  logic                   s1_valid_r;
  func_t                  s1_func_r;
  logic signed [15:0]     s1_angle_r;
  logic signed [7:0]      s1_speed_r;
  logic                   s1_cal_pre_r;

  logic [31:0]            mag_full;
  logic                   s2_valid_r;
  func_t                  s2_func_r;
  logic signed [15:0]     s2_angle_r;
  logic signed [7:0]      s2_speed_r;
  logic                   s2_cal_pre_r;
  logic                   s2_cal_post_r;
  logic                   s2_neg_r;
  logic                   s2_sat_p_r;
  logic                   s2_sat_n_r;
  logic [MAG_W-1:0]       s2_mag_r;

  logic [HPRD_W-1:0]      hprod;
  logic [16:0]            hq;
  logic [16:0]            hq_neg;
  logic signed [15:0]     heading_nxt;
  logic                   s3_valid_r;
  func_t                  s3_func_r;
  logic signed [15:0]     s3_angle_r;
  logic signed [7:0]      s3_speed_r;
  logic                   s3_cal_pre_r;
  logic                   s3_cal_post_r;
  logic signed [15:0]     s3_heading_r;

  logic                   turning_r, turning_nxt;
  logic signed [16:0]     target_r, target_nxt;
  logic signed [7:0]      speed_r, speed_nxt;
  logic                   cmd_turn;
  logic signed [17:0]     err;
  logic [17:0]            err_mag;
  logic signed [7:0]      speed_neg;
  out_t                   out_nxt;
  logic                   out_valid_r;
  out_t                   out_data_r;

  assign en        = !out_valid_r || !out_stall;
  assign in_stall  = !en;
  assign in_acc    = in_valid && en;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mount_rev_r <= 1'b0;
      deadband_r  <= DEADBAND_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_MOUNT_REV: mount_rev_r <= cfg_wdata[0];
        REG_DEADBAND:  deadband_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign cal_cnt_inc = cal_cnt_r + CNT_W'(1);
  assign cal_sum_inc = cal_sum_r + SUM_W'(in_data.gyro_sample);
  assign cal_fin     = (cal_cnt_inc >= CNT_W'(CAL_SAMPLES));
  assign cal_prod    = CPRD_W'(cal_sum_inc * CM);

  assign diff  = $signed({1'b0, in_data.gyro_sample}) - $signed({1'b0, zero_offset_r});
  assign rate  = mount_rev_r ? -diff : diff;
  assign delta = {{(31 - SAMPLE_BITS){rate[SAMPLE_BITS]}}, rate};

  always_comb begin
    cal_active_nxt  = cal_active_r;
    cal_cnt_nxt     = cal_cnt_r;
    cal_sum_nxt     = cal_sum_r;
    zero_offset_nxt = zero_offset_r;
    acc_nxt         = acc_r;
    if (in_acc) begin
      case (in_data.func)
        FUNC_TICK: begin
          if (cal_active_r) begin
            cal_sum_nxt = cal_sum_inc;
            cal_cnt_nxt = cal_cnt_inc;
            if (cal_fin) begin
              zero_offset_nxt = cal_prod[CK +: SAMPLE_BITS];
              cal_active_nxt  = 1'b0;
            end
          end else begin
            acc_nxt = acc_r + delta;
          end
        end
        FUNC_RECAL: begin
          cal_active_nxt = 1'b1;
          cal_cnt_nxt    = '0;
          cal_sum_nxt    = '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal_active_r  <= 1'b1;
      cal_cnt_r     <= '0;
      cal_sum_r     <= '0;
      zero_offset_r <= '0;
      acc_r         <= '0;
    end else begin
      cal_active_r  <= cal_active_nxt;
      cal_cnt_r     <= cal_cnt_nxt;
      cal_sum_r     <= cal_sum_nxt;
      zero_offset_r <= zero_offset_nxt;
      acc_r         <= acc_nxt;
    end
  end

  // The accumulator and calibration registers always hold the state left by
  // the item in stage one, because they change only when stage one loads.
  assign mag_full = acc_r[31] ? (32'd0 - acc_r) : acc_r;

  assign hprod       = HPRD_W'(s2_mag_r * HM);
  assign hq          = hprod[HK +: 17];
  assign hq_neg      = 17'd0 - hq;

  always_comb begin
    if (s2_sat_p_r) begin
      heading_nxt = 16'sh7FFF;
    end else if (s2_sat_n_r) begin
      heading_nxt = -16'sh8000;
    end else if (s2_neg_r) begin
      heading_nxt = $signed(hq_neg[15:0]);
    end else begin
      heading_nxt = $signed(hq[15:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
    end else if (en) begin
      s1_valid_r <= in_valid;
      s2_valid_r <= s1_valid_r;
      s3_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_func_r     <= in_data.func;
      s1_angle_r    <= in_data.turn_angle;
      s1_speed_r    <= in_data.turn_speed;
      s1_cal_pre_r  <= cal_active_r;

      s2_func_r     <= s1_func_r;
      s2_angle_r    <= s1_angle_r;
      s2_speed_r    <= s1_speed_r;
      s2_cal_pre_r  <= s1_cal_pre_r;
      s2_cal_post_r <= cal_active_r;
      s2_neg_r      <= acc_r[31];
      s2_sat_p_r    <= !acc_r[31] && (mag_full >= LIM_P);
      s2_sat_n_r    <= acc_r[31] && (mag_full >= LIM_N);
      s2_mag_r      <= mag_full[MAG_W-1:0];

      s3_func_r     <= s2_func_r;
      s3_angle_r    <= s2_angle_r;
      s3_speed_r    <= s2_speed_r;
      s3_cal_pre_r  <= s2_cal_pre_r;
      s3_cal_post_r <= s2_cal_post_r;
      s3_heading_r  <= heading_nxt;
    end
  end

  assign cmd_turn = ((s3_func_r == FUNC_TURN_ABS) || (s3_func_r == FUNC_TURN_REL)) &&
                    !s3_cal_pre_r;

  always_comb begin
    turning_nxt = turning_r;
    target_nxt  = target_r;
    speed_nxt   = speed_r;
    if (s3_func_r == FUNC_RECAL) begin
      turning_nxt = 1'b0;
    end else if (cmd_turn) begin
      turning_nxt = 1'b1;
      speed_nxt   = s3_speed_r;
      if (s3_func_r == FUNC_TURN_ABS) begin
        target_nxt = {s3_angle_r[15], s3_angle_r};
      end else begin
        target_nxt = $signed({s3_heading_r[15], s3_heading_r}) +
                     $signed({s3_angle_r[15], s3_angle_r});
      end
    end

    err       = $signed({{2{s3_heading_r[15]}}, s3_heading_r}) -
                $signed({target_nxt[16], target_nxt});
    err_mag   = err[17] ? 18'(-err) : 18'(err);
    speed_neg = (speed_nxt == -8'sd128) ? 8'sd127 : -speed_nxt;

    out_nxt.left_power  = '0;
    out_nxt.right_power = '0;
    out_nxt.heading     = s3_heading_r;
    out_nxt.calibrating = s3_cal_post_r;
    out_nxt.turn_done   = 1'b0;
    if (turning_nxt) begin
      if (err_mag > 18'(deadband_r)) begin
        if (err[17]) begin
          out_nxt.left_power  = speed_nxt;
          out_nxt.right_power = speed_neg;
        end else begin
          out_nxt.left_power  = speed_neg;
          out_nxt.right_power = speed_nxt;
        end
      end else begin
        turning_nxt       = 1'b0;
        out_nxt.turn_done = 1'b1;
      end
    end
    out_nxt.turn_active = turning_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      turning_r   <= 1'b0;
      target_r    <= '0;
      speed_r     <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= s3_valid_r;
      if (s3_valid_r) begin
        turning_r <= turning_nxt;
        target_r  <= target_nxt;
        speed_r   <= speed_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en && s3_valid_r) begin
      out_data_r <= out_nxt;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/ghtc_checker.sv
// ----------------------------------------------------------------------------
// Gyro heading turn controller checker
// Port-level assertions on flow control and result consistency.
// ----------------------------------------------------------------------------
`default_nettype none

module ghtc_checker import ghtc_pkg::*; (
  input logic clk,
  input logic rst_n,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input out_t out_data
);

  a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall == (out_valid && out_stall))
    else $error("Input stall does not follow a stalled output transaction.");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("Stalled output transaction changed.");

  a_cal_no_turn: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.calibrating |-> !out_data.turn_active && !out_data.turn_done)
    else $error("Turn reported while calibrating.");

  a_idle_power: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.turn_active |->
      out_data.left_power == 8'sd0 && out_data.right_power == 8'sd0)
    else $error("Wheel power driven without an active turn.");

  a_done_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.turn_done |-> !out_data.turn_active)
    else $error("Turn still active on its completion transaction.");

endmodule

bind gyro_heading_turn_controller_unit ghtc_checker u_ghtc_checker (.*);

`default_nettype wire
